### rtl/ipv4_text_parse_public_filter_unit_defines.svh
// Assertion macros shared by the IPv4 text parser RTL.
// Each macro expects clk_i and rst_ni in scope of the module that uses it.
`ifndef IPV4_TEXT_PARSE_PUBLIC_FILTER_UNIT_DEFINES_SVH
`define IPV4_TEXT_PARSE_PUBLIC_FILTER_UNIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define IPV4TPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define IPV4TPF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/ipv4tpf_pkg.sv
// Package for the IPv4 text parser: field widths, character codes and
// the excluded address ranges. No dependencies.
`default_nettype none

package ipv4tpf_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned AddrW = 32;
  localparam int unsigned OctW  = 9;   // holds 0..256, 256 marks saturation
  localparam int unsigned AccW  = 24;

  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;
  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChNul   = 8'h00;

  localparam logic [OctW-1:0] OctMax = 9'd255;
  localparam logic [OctW-1:0] OctSat = 9'd256;

  // Excluded ranges as mask/base pairs.
  localparam int unsigned NumRanges = 8;
  typedef logic [AddrW-1:0] addr_t;
  localparam addr_t RangeMask [NumRanges] = '{
    32'hFF000000, 32'hFFFF0000, 32'hFF000000, 32'hFFC00000,
    32'hFFF00000, 32'hFFFFFF00, 32'hFFFE0000, 32'hFF000000
  };
  localparam addr_t RangeBase [NumRanges] = '{
    32'h7F000000, 32'hC0A80000, 32'h0A000000, 32'h64400000,
    32'hAC100000, 32'hC0000000, 32'hC6120000, 32'h00000000
  };

endpackage

`default_nettype wire

### rtl/ipv4tpf_public_check.sv
// Public-address filter: flags an address outside all excluded ranges.
// Depends on ipv4tpf_pkg for the range table.
`default_nettype none

module ipv4tpf_public_check (
  input  wire ipv4tpf_pkg::addr_t addr_i,
  output logic                    public_o
);

  logic [ipv4tpf_pkg::NumRanges-1:0] hit;

  always_comb begin
    for (int i = 0; i < int'(ipv4tpf_pkg::NumRanges); i++) begin
      hit[i] = (addr_i & ipv4tpf_pkg::RangeMask[i]) == ipv4tpf_pkg::RangeBase[i];
    end
  end

  assign public_o = ~|hit;

endmodule

`default_nettype wire

### rtl/ipv4_text_parse_public_filter_unit.sv
// IPv4 dotted-decimal parser with public-address filter. Feed one string
// byte per transfer on the slave stream (tlast marks the final byte); the
// block takes one byte every cycle while ready and returns one result per
// string on the master stream in the cycle after the tlast transfer. The
// per-byte work is a small parse state update with a constant multiply by
// ten, done between the input handshake and the parse/result registers;
// a single output register holds the result, and the input stays ready as
// long as that register is empty or is being drained in the same cycle.
// Depends on ipv4tpf_pkg and ipv4tpf_public_check.
`default_nettype none

`include "ipv4_text_parse_public_filter_unit_defines.svh"

module ipv4_text_parse_public_filter_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Slave stream: string bytes
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // [7:0] char_in
  input  wire         s_axis_tlast_i,   // last_char
  // Master stream: parse result
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] ip_address
  output logic        m_axis_tuser_o    // [0] found
);

  typedef enum logic [3:0] {
    PhSkip   = 4'b0001,
    PhStart  = 4'b0010,
    PhDigits = 4'b0100,
    PhClosed = 4'b1000
  } phase_e;

  phase_e                            phase_q, phase_d;
  logic [1:0]                        idx_q, idx_d;
  logic [ipv4tpf_pkg::OctW-1:0]      oct_q, oct_d;
  logic [ipv4tpf_pkg::AccW-1:0]      acc_q, acc_d;
  logic                              verdict_q, verdict_d;

  logic                              out_valid_q, out_valid_d;
  ipv4tpf_pkg::addr_t                ip_q;
  logic                              found_q;

  logic                              in_xfer;
  logic [ipv4tpf_pkg::CharW-1:0]     ch;
  logic                              is_digit, is_ws;
  logic [11:0]                       times_ten;
  ipv4tpf_pkg::addr_t                full_addr;
  logic                              is_public;
  logic                              final_verdict;

  assign ch       = s_axis_tdata_i;
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign is_digit = (ch >= ipv4tpf_pkg::ChZero) && (ch <= ipv4tpf_pkg::ChNine);
  assign is_ws    = (ch == ipv4tpf_pkg::ChSpace) ||
                    ((ch >= ipv4tpf_pkg::ChTab) && (ch <= ipv4tpf_pkg::ChCr));

  // Octet value is at most 255 while digits are being collected.
  assign times_ten = 12'(oct_q[7:0]) * 12'd10 + 12'(ch[3:0]);

  // Filter sees the address built from the next state; when the fourth
  // octet closes on a space the state is unchanged, so one check serves both.
  assign full_addr = {acc_d, oct_d[7:0]};

  ipv4tpf_public_check u_public_check (
    .addr_i   (full_addr),
    .public_o (is_public)
  );

  // Parse step for one byte.
  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    oct_d     = oct_q;
    acc_d     = acc_q;
    verdict_d = verdict_q;
    unique case (phase_q)
      PhSkip: begin
        if (is_ws) begin
          // keep skipping
        end else if (is_digit) begin
          oct_d   = 9'(ch[3:0]);
          phase_d = PhDigits;
        end else begin
          phase_d   = PhClosed;
          verdict_d = 1'b0;
        end
      end
      PhStart: begin
        if (is_digit) begin
          oct_d   = 9'(ch[3:0]);
          phase_d = PhDigits;
        end else begin
          phase_d   = PhClosed;
          verdict_d = 1'b0;
        end
      end
      PhDigits: begin
        if (is_digit) begin
          if (times_ten > 12'(ipv4tpf_pkg::OctMax)) begin
            // Saturate and fail at once.
            oct_d     = ipv4tpf_pkg::OctSat;
            phase_d   = PhClosed;
            verdict_d = 1'b0;
          end else begin
            oct_d = times_ten[8:0];
          end
        end else if (idx_q != 2'd3) begin
          if (ch == ipv4tpf_pkg::ChDot) begin
            acc_d   = {acc_q[15:0], oct_q[7:0]};
            idx_d   = idx_q + 2'd1;
            oct_d   = '0;
            phase_d = PhStart;
          end else begin
            phase_d   = PhClosed;
            verdict_d = 1'b0;
          end
        end else begin
          phase_d   = PhClosed;
          verdict_d = ((ch == ipv4tpf_pkg::ChSpace) || (ch == ipv4tpf_pkg::ChNul)) &&
                      is_public;
        end
      end
      PhClosed: begin
        // ignore bytes until the end of the string
      end
      default: begin
        // unreachable codes act as closed
      end
    endcase
  end

  // End of string completes a fourth octet in progress, fails elsewhere.
  always_comb begin
    if (phase_d == PhDigits && idx_d == 2'd3) begin
      final_verdict = is_public;
    end else if (phase_d != PhClosed) begin
      final_verdict = 1'b0;
    end else begin
      final_verdict = verdict_d;
    end
  end

  // Accept a byte whenever the result register is free or draining.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer && s_axis_tlast_i) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSkip;
      idx_q       <= '0;
      oct_q       <= '0;
      acc_q       <= '0;
      verdict_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        if (s_axis_tlast_i) begin
          // Return to reset values for the next string.
          phase_q   <= PhSkip;
          idx_q     <= '0;
          oct_q     <= '0;
          acc_q     <= '0;
          verdict_q <= 1'b0;
        end else begin
          phase_q   <= phase_d;
          idx_q     <= idx_d;
          oct_q     <= oct_d;
          acc_q     <= acc_d;
          verdict_q <= verdict_d;
        end
      end
    end
  end

  // Result payload: load on the final byte, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_xfer && s_axis_tlast_i) begin
      ip_q    <= final_verdict ? full_addr : '0;
      found_q <= final_verdict;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = ip_q;
  assign m_axis_tuser_o  = found_q;

  `IPV4TPF_ASSERT(a_notfound_zero, m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == 32'd0, "not-found result carries a nonzero address")
  `IPV4TPF_ASSERT(a_found_public, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[31:24] != 8'd0 && m_axis_tdata_o[31:24] != 8'd127 && m_axis_tdata_o[31:24] != 8'd10, "found address lies in an excluded range")
  `IPV4TPF_ASSERT_NEXT(a_last_gives_result, in_xfer && s_axis_tlast_i, m_axis_tvalid_o, "final byte transfer did not produce a result")
  `IPV4TPF_ASSERT_NEXT(a_last_resets_parse, in_xfer && s_axis_tlast_i, phase_q == PhSkip && idx_q == 2'd0 && !verdict_q, "parse state not cleared after final byte")

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for ipv4_text_parse_public_filter_unit: streams text strings
// byte by byte, tracks the parse in a local predictor and checks every result transfer.
// Depends on ipv4tpf_pkg and the unit under test.

module testbench;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned HoldLen    = 400;
  localparam int unsigned NumBlocks  = 8;

  // Non-public ranges as mask/base pairs, checked in this order.
  localparam logic [31:0] BlockMask [NumBlocks] = '{
    32'hFF000000, 32'hFFFF0000, 32'hFF000000, 32'hFFC00000,
    32'hFFF00000, 32'hFFFFFF00, 32'hFFFE0000, 32'hFF000000
  };
  localparam logic [31:0] BlockBase [NumBlocks] = '{
    32'h7F000000, 32'hC0A80000, 32'h0A000000, 32'h64400000,
    32'hAC100000, 32'hC0000000, 32'hC6120000, 32'h00000000
  };

  typedef enum logic [2:0] {
    SCAN_WS   = 3'd0,
    SCAN_LEAD = 3'd1,
    SCAN_NUM  = 3'd2,
    SCAN_DONE = 3'd3
  } scan_e;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC
  } rx_mode_e;

  typedef struct packed {
    logic [31:0] addr;
    logic        found;
  } verdict_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  ipv4_text_parse_public_filter_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),         // [7:0] char_in
    .s_axis_tlast_i  (s_tlast),         // last_char
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // [31:0] ip_address
    .m_axis_tuser_o  (m_axis_tuser_o)   // [0] found
  );

  always #5 clk_i = ~clk_i;

  // Predictor state for the string in flight.
  scan_e       scan    = SCAN_WS;
  logic [1:0]  oct_idx = 2'd0;
  logic [8:0]  oct_val = 9'd0;
  logic [23:0] acc_hi  = 24'd0;
  logic        hit     = 1'b0;

  verdict_t    pending_verdicts[$];
  logic [7:0]  text_buf[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  logic        tx_gaps     = 1'b0;
  rx_mode_e    rx_mode     = RX_ALWAYS;
  logic        hold_kick   = 1'b0;
  logic        hold_seen   = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned rx_tick     = 0;

  // ---------------------------------------------------------------------------
  // Parse predictor
  // ---------------------------------------------------------------------------
  function automatic logic is_blank(input logic [7:0] ch);
    return ch == ipv4tpf_pkg::ChSpace ||
           (ch >= ipv4tpf_pkg::ChTab && ch <= ipv4tpf_pkg::ChCr);
  endfunction

  function automatic logic is_num(input logic [7:0] ch);
    return ch >= ipv4tpf_pkg::ChZero && ch <= ipv4tpf_pkg::ChNine;
  endfunction

  function automatic logic is_public(input logic [31:0] a);
    for (int i = 0; i < NumBlocks; i++) begin
      if ((a & BlockMask[i]) == BlockBase[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void close_octets();
    scan = SCAN_DONE;
    hit  = is_public({acc_hi, oct_val[7:0]});
  endfunction

  function automatic void reject_text();
    scan = SCAN_DONE;
    hit  = 1'b0;
  endfunction

  function automatic void clear_parse();
    scan    = SCAN_WS;
    oct_idx = 2'd0;
    oct_val = 9'd0;
    acc_hi  = 24'd0;
    hit     = 1'b0;
  endfunction

  // Advance the parse by one accepted byte; queue the verdict at end of string.
  function automatic void advance_parse(input logic [7:0] ch, input logic eos);
    int unsigned v;
    verdict_t    res;
    case (scan)
      SCAN_WS: begin
        if (is_num(ch)) begin
          oct_val = 9'(ch - ipv4tpf_pkg::ChZero);
          scan    = SCAN_NUM;
        end else if (!is_blank(ch)) begin
          reject_text();
        end
      end
      SCAN_LEAD: begin
        if (is_num(ch)) begin
          oct_val = 9'(ch - ipv4tpf_pkg::ChZero);
          scan    = SCAN_NUM;
        end else begin
          reject_text();
        end
      end
      SCAN_NUM: begin
        if (is_num(ch)) begin
          v = oct_val * 10 + (ch - ipv4tpf_pkg::ChZero);
          if (v > 255) begin
            oct_val = ipv4tpf_pkg::OctSat;
            reject_text();
          end else begin
            oct_val = 9'(v);
          end
        end else if (oct_idx < 2'd3) begin
          if (ch == ipv4tpf_pkg::ChDot) begin
            acc_hi  = {acc_hi[15:0], oct_val[7:0]};
            oct_idx = oct_idx + 2'd1;
            oct_val = 9'd0;
            scan    = SCAN_LEAD;
          end else begin
            reject_text();
          end
        end else if (ch == ipv4tpf_pkg::ChSpace || ch == ipv4tpf_pkg::ChNul) begin
          close_octets();
        end else begin
          reject_text();
        end
      end
      default: ;
    endcase

    if (eos) begin
      // end of string completes a fourth octet in progress, fails anything else open
      if (scan == SCAN_NUM && oct_idx == 2'd3) close_octets();
      else if (scan != SCAN_DONE) reject_text();
      res.addr  = hit ? {acc_hi, oct_val[7:0]} : 32'd0;
      res.found = hit;
      pending_verdicts.push_back(res);
      clear_parse();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one byte per call, bursts of random length with optional idle gaps
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] ch, input logic eos);
    int unsigned gap;
    if (tx_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready_o);
    advance_parse(ch, eos);
    if (burst_left != 0) burst_left--;
    items_sent++;
  endtask

  // Send the buffered string, tlast on its final byte, then empty the buffer.
  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      send_char(text_buf[i], i == text_buf.size() - 1);
    end
    text_buf.delete();
  endtask

  // ---------------------------------------------------------------------------
  // String builders
  // ---------------------------------------------------------------------------
  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic void push_octet(input int unsigned v);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) text_buf.push_back(ipv4tpf_pkg::ChZero);
    end
    push_text($sformatf("%0d", v));
  endfunction

  function automatic logic [7:0] pick_blank();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? ipv4tpf_pkg::ChSpace : 8'(ipv4tpf_pkg::ChTab + k);
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 4))
      0, 1:    return 8'(ipv4tpf_pkg::ChZero + $urandom_range(0, 9));
      2:       return ipv4tpf_pkg::ChDot;
      3:       return pick_blank();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly addresses in or next to the excluded ranges, some fully random.
  function automatic logic [31:0] pick_address();
    int unsigned k;
    logic [31:0] a;
    k = $urandom_range(0, 11);
    if (k >= NumBlocks) return $urandom;
    a = BlockBase[k] | ($urandom & ~BlockMask[k]);
    case ($urandom_range(0, 3))
      0:       a = BlockBase[k] - 32'd1;
      1:       a = (BlockBase[k] | ~BlockMask[k]) + 32'd1;
      default: ;
    endcase
    return a;
  endfunction

  function automatic void build_random_text();
    int unsigned kind;
    int unsigned pos;
    int unsigned v;
    logic [31:0] a;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      repeat ($urandom_range(0, 2)) text_buf.push_back(pick_blank());
      a = pick_address();
      for (int i = 0; i < 4; i++) begin
        v = a[31 - 8*i -: 8];
        if ($urandom_range(0, 29) == 0) v = $urandom_range(256, 999);
        push_octet(v);
        if (i < 3) text_buf.push_back(ipv4tpf_pkg::ChDot);
      end
      // terminator: end of string, space or zero byte, then ignored tail
      case ($urandom_range(0, 2))
        1:       text_buf.push_back(ipv4tpf_pkg::ChSpace);
        2:       text_buf.push_back(ipv4tpf_pkg::ChNul);
        default: ;
      endcase
      if (text_buf[text_buf.size() - 1] inside {ipv4tpf_pkg::ChSpace,
                                                 ipv4tpf_pkg::ChNul}) begin
        repeat ($urandom_range(0, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
      end
      // break one byte of the sequence
      if (kind == 6) begin
        pos = $urandom_range(0, text_buf.size() - 1);
        if ($urandom_range(0, 1) == 0 || text_buf.size() < 2) begin
          text_buf[pos] = 8'($urandom_range(0, 255));
        end else begin
          text_buf.delete(pos);
        end
      end
    end else begin
      repeat ($urandom_range(1, 8)) text_buf.push_back(noise_byte());
    end
  endfunction

  task automatic run_random(input int unsigned target);
    while (items_sent < target) begin
      build_random_text();
      send_text();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern per mode, plus a counted hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rx_tick <= (rx_tick == 6) ? 0 : rx_tick + 1;
    if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= HoldLen;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: m_tready <= 1'b1;
        RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
        default:   m_tready <= (rx_tick != 0 && rx_tick != 3);
      endcase
    end
  end

  // Compare each result transfer with the oldest pending verdict.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with no pending verdict: ip_address %08h found %0b",
               m_axis_tdata_o, m_axis_tuser_o);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata_o !== want.addr) begin
          $error("ip_address: expected %08h, actual %08h", want.addr, m_axis_tdata_o);
          error_count++;
        end
        if (m_axis_tuser_o !== want.found) begin
          $error("found: expected %0b, actual %0b", want.found, m_axis_tuser_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Byte extremes and special cases of the parse.
  task automatic test_directed();
    tx_gaps = 1'b0;
    rx_mode <= RX_ALWAYS;
    push_text("\t9.9.9.9 z");        // leading blank, space ends, tail ignored
    send_text();
    text_buf.push_back(8'hFF);       // non-digit first byte
    send_text();
    text_buf.push_back(ipv4tpf_pkg::ChNul);  // zero byte first
    send_text();
    push_text("260");                // oversized octet
    send_text();
    push_text("1;");                 // bad terminator on first octet
    send_text();
    push_text("1.2");                // string ends before fourth octet
    send_text();
    push_text("10.0.0.1");           // private range, zero byte ends
    text_buf.push_back(ipv4tpf_pkg::ChNul);
    send_text();
  endtask

  // Back-to-back transfers on both sides.
  task automatic test_full_rate(input int unsigned target);
    tx_gaps = 1'b0;
    rx_mode <= RX_ALWAYS;
    run_random(target);
  endtask

  // Sender bursts against random and periodic receiver stalls.
  task automatic test_bursty(input int unsigned target);
    tx_gaps = 1'b1;
    rx_mode <= RX_RANDOM;
    run_random(target - (target - items_sent) / 2);
    rx_mode <= RX_PERIODIC;
    run_random(target);
  endtask

  // Long receiver hold-off while the sender keeps offering: the result register
  // fills and the input must stall until it drains.
  task automatic test_backpressure(input int unsigned target);
    tx_gaps = 1'b0;
    rx_mode <= RX_ALWAYS;
    hold_kick <= ~hold_kick;
    run_random(target);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_rate(items_sent + 450);
    test_bursty(items_sent + 1200);
    test_backpressure(items_sent + 300);

    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
